// ===== hw/rtl/pica_pkg.sv =====
// Shared types, constants and saturation helpers for the PI heater controller.
// No dependencies; used by pica_ctrl, pica_dpath and pi_controller_antiwindup.
package pica_pkg;

   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_P_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_I_GAIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_PWM  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_TC  = 3'd4;

   localparam logic [15:0] MAX_PWM_RST = 16'hFFFF;
   localparam logic [15:0] RATE_TC_RST = 16'd4096;

   localparam int unsigned NUM_W     = 42;
   localparam int unsigned DIV_STEPS = 21;
   localparam int unsigned CNT_W     = 5;

   localparam logic signed [18:0] FAN_BIAS = 19'sd13107;

   typedef struct packed {
      logic [15:0] setpoint;
      logic [15:0] p_gain;
      logic [15:0] i_gain;
      logic [15:0] max_pwm;
      logic [15:0] rate_tc;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic mul1;
      logic mul2;
      logic pi1;
      logic pi2;
      logic div_step;
      logic fin;
      logic out_load;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_PI1,
      ST_PI2,
      ST_DIV,
      ST_FIN,
      ST_OUT
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -40'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [43:0] v);
      logic signed [23:0] r;
      if (v > 44'sd8388607) begin
         r = 24'sh7FFFFF;
      end else if (v < -44'sd8388608) begin
         r = 24'sh800000;
      end else begin
         r = v[23:0];
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/pi_controller_antiwindup.sv =====
// Top level of the PI heater controller with anti-windup clamp and rate filter.
// Holds the settings registers; instantiates pica_ctrl and pica_dpath, uses pica_pkg.
//
//   channel  direction  accepted when             carries
//   req_     in         req_tvalid & req_tready   temperature, delta_time
//   rsp_     out        rsp_tvalid & rsp_tready   heater_pwm, fan_drive, temperature_rate
//   csr_     in         csr_valid & csr_ready     register index, write data
//
// After a request is accepted, the sequencer runs two multiply steps, two integral steps,
// 21 divider steps (two quotient bits each, 42-bit numerator), a filter update and the
// result load. The next request is taken only in idle, after that result load.
// Synchronous active-high reset clears the integral, last temperature and rate filter and
// returns the settings to their defaults. A stalled result holds in the output register; the
// next request is taken meanwhile, and its result waits until the held one is taken.
module pi_controller_antiwindup (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [31:0]                    req_tdata,  // temperature[15:0], delta_time[31:16]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [55:0]                    rsp_tdata,  // heater_pwm[15:0], fan_drive[34:16],
                                                      // temperature_rate[50:35], zero above
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pica_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                    csr_data
);

   pica_pkg::cfg_type cfg_ff;
   pica_pkg::cmd_type cmd;

   logic [15:0]        heater_pwm;
   logic signed [18:0] fan_drive;
   logic signed [15:0] temperature_rate;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint <= '0;
         cfg_ff.p_gain   <= '0;
         cfg_ff.i_gain   <= '0;
         cfg_ff.max_pwm  <= pica_pkg::MAX_PWM_RST;
         cfg_ff.rate_tc  <= pica_pkg::RATE_TC_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            pica_pkg::REG_SETPOINT: cfg_ff.setpoint <= csr_data;
            pica_pkg::REG_P_GAIN:   cfg_ff.p_gain   <= csr_data;
            pica_pkg::REG_I_GAIN:   cfg_ff.i_gain   <= csr_data;
            pica_pkg::REG_MAX_PWM:  cfg_ff.max_pwm  <= csr_data;
            pica_pkg::REG_RATE_TC:  cfg_ff.rate_tc  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   pica_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   pica_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cfg              (cfg_ff),
      .temperature      ($signed(req_tdata[15:0])),
      .delta_time       (req_tdata[31:16]),
      .heater_pwm       (heater_pwm),
      .fan_drive        (fan_drive),
      .temperature_rate (temperature_rate)
   );

   assign rsp_tdata = {5'd0, temperature_rate, fan_drive, heater_pwm};

endmodule

// ===== hw/rtl/pica_ctrl.sv =====
// Sequencer for the PI heater controller: steps the datapath through one sample.
// Depends on pica_pkg (state_type, cmd_type, step count).
module pica_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output pica_pkg::cmd_type cmd
);

   pica_pkg::state_type state_ff, state_in;
   logic [pica_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pica_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         pica_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = pica_pkg::ST_MUL1;
            end
         end
         pica_pkg::ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = pica_pkg::ST_MUL2;
         end
         pica_pkg::ST_MUL2: begin
            cmd.mul2 = 1'b1;
            cnt_in   = '0;
            state_in = pica_pkg::ST_PI1;
         end
         pica_pkg::ST_PI1: begin
            cmd.pi1  = 1'b1;
            state_in = pica_pkg::ST_PI2;
         end
         pica_pkg::ST_PI2: begin
            cmd.pi2  = 1'b1;
            state_in = pica_pkg::ST_DIV;
         end
         pica_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == pica_pkg::CNT_W'(pica_pkg::DIV_STEPS - 1)) begin
               state_in = pica_pkg::ST_FIN;
            end
         end
         pica_pkg::ST_FIN: begin
            cmd.fin  = 1'b1;
            state_in = pica_pkg::ST_OUT;
         end
         pica_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = pica_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pica_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== hw/rtl/pica_dpath.sv =====
// Datapath of the PI heater controller: products, integral clamp, rate filter divider
// and the result register. Depends on pica_pkg (cfg_type, cmd_type, sat32, sat24).
module pica_dpath (
   input  logic                clock,
   input  logic                reset,
   input  pica_pkg::cmd_type   cmd,
   input  pica_pkg::cfg_type   cfg,
   input  logic signed [15:0]  temperature,
   input  logic [15:0]         delta_time,
   output logic [15:0]         heater_pwm,
   output logic signed [18:0]  fan_drive,
   output logic signed [15:0]  temperature_rate
);

   localparam int unsigned NW = pica_pkg::NUM_W;

   // sample state
   logic signed [31:0] int_ff, int_in;
   logic signed [15:0] last_ff;
   logic signed [23:0] rate_ff, rate_in;

   // operands
   logic signed [16:0] err_ff, err_in;
   logic signed [16:0] dtemp_ff, dtemp_in;
   logic [15:0]        dt_ff;
   logic [31:0]        gdt_ff, gdt_in;
   logic signed [33:0] ptrm_ff, ptrm_in;
   logic signed [40:0] rprod_ff, rprod_in;
   logic signed [49:0] iprod_ff, iprod_in;
   logic signed [31:0] acc_ff, acc_in;
   logic [15:0]        pwm_ff, pwm_in;
   logic               neg_ff;
   logic [15:0]        rem_ff, rem_in;
   logic [NW-1:0]      quo_ff, quo_in;

   // results
   logic [15:0]        rsp_pwm_ff;
   logic signed [18:0] rsp_fan_ff, fan_in;
   logic signed [15:0] rsp_rate_ff;

   logic signed [NW-1:0] num;
   logic [NW-1:0]        mag;
   logic [15:0]          tc_eff;
   logic signed [37:0]   inc;
   logic signed [38:0]   isum;
   logic signed [34:0]   out_sum;
   logic signed [34:0]   ptrm_x;
   logic signed [34:0]   max_x;
   logic signed [NW:0]   quo_s;
   logic signed [43:0]   rsum;
   logic signed [18:0]   fan_d;

   assign tc_eff = (cfg.rate_tc == 16'd0) ? 16'd1 : cfg.rate_tc;

   always_comb begin
      err_in   = $signed({cfg.setpoint[15], cfg.setpoint}) - $signed({temperature[15], temperature});
      dtemp_in = $signed({temperature[15], temperature}) - $signed({last_ff[15], last_ff});
      gdt_in   = 32'(cfg.i_gain) * 32'(dt_ff);
      ptrm_in  = $signed({1'b0, cfg.p_gain}) * err_ff;
      rprod_in = rate_ff * $signed({1'b0, dt_ff});
      iprod_in = $signed({1'b0, gdt_ff}) * err_ff;
      num      = $signed({dtemp_ff, 20'd0}) - rprod_ff;
      mag      = num[NW-1] ? NW'(-num) : NW'(num);
   end

   always_comb begin
      inc    = iprod_ff[49:12];
      isum   = $signed({{7{int_ff[31]}}, int_ff}) + $signed({inc[37], inc});
      acc_in = (cfg.i_gain == 16'd0) ? 32'sd0 : pica_pkg::sat32(40'(isum));
   end

   always_comb begin
      ptrm_x  = $signed({ptrm_ff[33], ptrm_ff});
      max_x   = $signed({19'd0, cfg.max_pwm});
      out_sum = ptrm_x + $signed({{3{acc_ff[31]}}, acc_ff});
      priority if (out_sum > max_x) begin
         int_in = pica_pkg::sat32(40'(max_x - ptrm_x));
         pwm_in = cfg.max_pwm;
      end else if (out_sum[34]) begin
         int_in = pica_pkg::sat32(40'(-ptrm_x));
         pwm_in = 16'd0;
      end else begin
         int_in = acc_ff;
         pwm_in = out_sum[15:0];
      end
   end

   // two restoring division steps a cycle
   always_comb begin
      logic [16:0]   rem_sh;
      logic [15:0]   rem_v;
      logic [NW-1:0] quo_v;
      rem_v = rem_ff;
      quo_v = quo_ff;
      for (int i = 0; i < 2; i++) begin
         rem_sh = {rem_v, quo_v[NW-1]};
         quo_v  = {quo_v[NW-2:0], 1'b0};
         if (rem_sh >= {1'b0, tc_eff}) begin
            rem_sh   = rem_sh - {1'b0, tc_eff};
            quo_v[0] = 1'b1;
         end
         rem_v = rem_sh[15:0];
      end
      rem_in = rem_v;
      quo_in = quo_v;
   end

   always_comb begin
      quo_s   = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      rsum    = $signed({{20{rate_ff[23]}}, rate_ff}) + 44'(quo_s);
      rate_in = pica_pkg::sat24(rsum);
      fan_d   = pica_pkg::FAN_BIAS - $signed({3'd0, pwm_ff});
      fan_in  = 19'(fan_d <<< 2) + fan_d;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         int_ff  <= '0;
         last_ff <= '0;
         rate_ff <= '0;
      end else begin
         if (cmd.load) begin
            last_ff <= temperature;
         end
         if (cmd.pi2) begin
            int_ff <= int_in;
         end
         if (cmd.fin) begin
            rate_ff <= rate_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         err_ff   <= err_in;
         dtemp_ff <= dtemp_in;
         dt_ff    <= delta_time;
      end
      if (cmd.mul1) begin
         gdt_ff   <= gdt_in;
         ptrm_ff  <= ptrm_in;
         rprod_ff <= rprod_in;
      end
      if (cmd.mul2) begin
         iprod_ff <= iprod_in;
         neg_ff   <= num[NW-1];
         quo_ff   <= mag;
         rem_ff   <= '0;
      end
      if (cmd.pi1) begin
         acc_ff <= acc_in;
      end
      if (cmd.pi2) begin
         pwm_ff <= pwm_in;
      end
      if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
      if (cmd.out_load) begin
         rsp_pwm_ff  <= pwm_ff;
         rsp_fan_ff  <= fan_in;
         rsp_rate_ff <= rate_ff[23:8];
      end
   end

   assign heater_pwm       = rsp_pwm_ff;
   assign fan_drive        = rsp_fan_ff;
   assign temperature_rate = rsp_rate_ff;

endmodule
